// ----- src/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the ray / sphere intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // default fraction width of the fixed point formats
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    // register indexes, one 8-byte slot each
    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_RADIUS_SQ = 3'd4,
        REG_MATERIAL  = 3'd5
    } t_reg_idx;

    // sphere description held in the register file
    typedef struct packed {
        logic [2:0][31:0] c;        // center, signed per lane
        logic [30:0]      radius;
        logic [61:0]      rsq;
        logic [15:0]      material;
    } t_cfg;

    // one ray
    typedef struct packed {
        logic [2:0][31:0] o;        // origin, signed per lane
        logic [2:0][31:0] d;        // direction, signed per lane
        logic [31:0]      tmin;
        logic [31:0]      tmax;
    } t_ray;

    // one result
    typedef struct packed {
        logic             hit;
        logic [31:0]      t;
        logic [2:0][31:0] p;
        logic [2:0][31:0] n;
        logic [15:0]      material;
    } t_hit;

endpackage

// ----- src/rsi_datapath.sv -----
// ----------------------------------------------------------------------------
// rsi_datapath
// Fully pipelined intersection datapath: quadratic terms, discriminant,
// bit-per-stage square root, two root dividers, hit point and normal divider.
// ----------------------------------------------------------------------------
module rsi_datapath #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  rsi_pkg::t_ray i_ray,
    input  rsi_pkg::t_cfg i_cfg,
    output logic          o_vld,
    output rsi_pkg::t_hit o_res
);
    import rsi_pkg::*;

    localparam int SQ_N   = 66;                 // root bits
    localparam int DISC_W = 2 * SQ_N;           // discriminant magnitude bits
    localparam int REM_W  = SQ_N + 2;
    localparam int A_W    = 64;
    localparam int NUM_W  = SQ_N + 1 + FRAC_BITS;   // shifted root numerator
    localparam int QT_W   = NUM_W + 1;          // signed t
    localparam int ND_W   = 33 + FRAC_BITS;     // shifted normal numerator
    localparam int RAD_W  = 31;

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld;
    logic r_s8_vld, r_s9_vld, r_s10_vld, r_s11_vld, r_s12_vld, r_s13_vld;
    logic r_s14_vld, r_s15_vld, r_s16_vld, r_s17_vld;

    t_ray               r_s1_ray;
    logic signed [32:0] r_s1_oc [3];

    t_ray               r_s2_ray;
    logic signed [63:0] r_s2_dd [3];
    logic signed [64:0] r_s2_od [3];
    logic signed [65:0] r_s2_oo [3];

    t_ray               r_s3_ray;
    logic [A_W-1:0]     r_s3_a;
    logic signed [65:0] r_s3_hb;
    logic signed [66:0] r_s3_c;

    t_ray               r_s4_ray;
    logic [A_W-1:0]     r_s4_a;
    logic signed [65:0] r_s4_hb;
    logic [64:0]        r_s4_hbm;
    logic [65:0]        r_s4_cm;
    logic               r_s4_cneg;
    logic               r_s4_azero;

    t_ray               r_s5_ray;
    logic [A_W-1:0]     r_s5_a;
    logic signed [65:0] r_s5_hb;
    logic               r_s5_cneg;
    logic               r_s5_azero;
    logic [65:0]        r_s5_hh, r_s5_hl, r_s5_ll;
    logic [65:0]        r_s5_p11, r_s5_p10, r_s5_p01, r_s5_p00;

    t_ray               r_s6_ray;
    logic [A_W-1:0]     r_s6_a;
    logic signed [65:0] r_s6_hb;
    logic               r_s6_cneg;
    logic               r_s6_azero;
    logic [131:0]       r_s6_hb2, r_s6_ac;

    t_ray               r_s7_ray;
    logic [A_W-1:0]     r_s7_a;
    logic signed [65:0] r_s7_hb;
    logic               r_s7_miss;
    logic [DISC_W-1:0]  r_s7_disc;

    // square root stages
    logic               r_sq_vld  [SQ_N];
    logic               r_sq_miss [SQ_N];
    logic [REM_W-1:0]   r_sq_rem  [SQ_N];
    logic [SQ_N-1:0]    r_sq_root [SQ_N];
    logic [DISC_W-1:0]  r_sq_rad  [SQ_N];
    logic signed [65:0] r_sq_hb   [SQ_N];
    logic [A_W-1:0]     r_sq_a    [SQ_N];
    t_ray               r_sq_ray  [SQ_N];
    logic               n_sq_vld  [SQ_N];
    logic               n_sq_miss [SQ_N];
    logic [REM_W-1:0]   n_sq_rem  [SQ_N];
    logic [SQ_N-1:0]    n_sq_root [SQ_N];
    logic [DISC_W-1:0]  n_sq_rad  [SQ_N];
    logic signed [65:0] n_sq_hb   [SQ_N];
    logic [A_W-1:0]     n_sq_a    [SQ_N];
    t_ray               n_sq_ray  [SQ_N];

    t_ray               r_s8_ray;
    logic [A_W-1:0]     r_s8_a;
    logic               r_s8_miss;
    logic signed [67:0] r_s8_num [2];

    t_ray               r_s9_ray;
    logic [A_W-1:0]     r_s9_a;
    logic               r_s9_miss;
    logic [1:0]         r_s9_neg;
    logic [66:0]        r_s9_mag [2];

    // root divider stages
    logic               r_dv_vld  [NUM_W];
    logic               r_dv_miss [NUM_W];
    logic [1:0]         r_dv_neg  [NUM_W];
    logic [A_W-1:0]     r_dv_rem  [NUM_W][2];
    logic [NUM_W-1:0]   r_dv_wrd  [NUM_W][2];
    logic [A_W-1:0]     r_dv_a    [NUM_W];
    t_ray               r_dv_ray  [NUM_W];
    logic               n_dv_vld  [NUM_W];
    logic               n_dv_miss [NUM_W];
    logic [1:0]         n_dv_neg  [NUM_W];
    logic [A_W-1:0]     n_dv_rem  [NUM_W][2];
    logic [NUM_W-1:0]   n_dv_wrd  [NUM_W][2];
    logic [A_W-1:0]     n_dv_a    [NUM_W];
    t_ray               n_dv_ray  [NUM_W];

    t_ray                  r_s10_ray;
    logic                  r_s10_miss;
    logic signed [QT_W-1:0] r_s10_t [2];

    t_ray               r_s11_ray;
    logic               r_s11_hit;
    logic [31:0]        r_s11_t;

    logic               r_s12_hit;
    logic [31:0]        r_s12_t;
    logic [2:0][31:0]   r_s12_o;
    logic signed [63:0] r_s12_prod [3];

    logic               r_s13_hit;
    logic [31:0]        r_s13_t;
    logic [2:0][31:0]   r_s13_p;

    logic               r_s14_hit;
    logic [31:0]        r_s14_t;
    logic [2:0][31:0]   r_s14_p;
    logic signed [32:0] r_s14_diff [3];

    logic               r_s15_hit;
    logic [31:0]        r_s15_t;
    logic [2:0][31:0]   r_s15_p;
    logic [2:0]         r_s15_neg;
    logic [32:0]        r_s15_mag [3];

    // normal divider stages
    logic               r_nd_vld [ND_W];
    logic               r_nd_hit [ND_W];
    logic [31:0]        r_nd_t   [ND_W];
    logic [2:0][31:0]   r_nd_p   [ND_W];
    logic [2:0]         r_nd_neg [ND_W];
    logic [RAD_W-1:0]   r_nd_rem [ND_W][3];
    logic [ND_W-1:0]    r_nd_wrd [ND_W][3];
    logic               n_nd_vld [ND_W];
    logic               n_nd_hit [ND_W];
    logic [31:0]        n_nd_t   [ND_W];
    logic [2:0][31:0]   n_nd_p   [ND_W];
    logic [2:0]         n_nd_neg [ND_W];
    logic [RAD_W-1:0]   n_nd_rem [ND_W][3];
    logic [ND_W-1:0]    n_nd_wrd [ND_W][3];

    logic                   r_s16_hit;
    logic [31:0]            r_s16_t;
    logic [2:0][31:0]       r_s16_p;
    logic signed [ND_W:0]   r_s16_n [3];

    t_hit               r_s17_res;

    // combinational helpers
    logic signed [65:0]  n_hb_abs;
    logic signed [66:0]  n_c_abs;
    logic signed [132:0] n_disc;
    logic signed [67:0]  n_num_abs [2];
    logic signed [QT_W-1:0] n_tmin, n_tmax;
    logic [1:0]          n_ok;
    logic signed [63:0]  n_sh [3];
    logic signed [64:0]  n_sum [3];
    logic signed [32:0]  n_dabs [3];

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            for (int k = 0; k < SQ_N; k++) r_sq_vld[k] <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            for (int k = 0; k < NUM_W; k++) r_dv_vld[k] <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            r_s14_vld <= 1'b0;
            r_s15_vld <= 1'b0;
            for (int k = 0; k < ND_W; k++) r_nd_vld[k] <= 1'b0;
            r_s16_vld <= 1'b0;
            r_s17_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_sq_vld  <= n_sq_vld;
            r_s8_vld  <= r_sq_vld[SQ_N-1];
            r_s9_vld  <= r_s8_vld;
            r_dv_vld  <= n_dv_vld;
            r_s10_vld <= r_dv_vld[NUM_W-1];
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
            r_s14_vld <= r_s13_vld;
            r_s15_vld <= r_s14_vld;
            r_nd_vld  <= n_nd_vld;
            r_s16_vld <= r_nd_vld[ND_W-1];
            r_s17_vld <= r_s16_vld;
        end
    end

    // ------------------------------------------------------------------
    // quadratic terms
    // ------------------------------------------------------------------
    // offset origin from center
    always_ff @(posedge i_clk) begin
        r_s1_ray <= i_ray;
        for (int i = 0; i < 3; i++)
            r_s1_oc[i] <= 33'($signed(i_ray.o[i])) - 33'($signed(i_cfg.c[i]));
    end

    // per-lane products
    always_ff @(posedge i_clk) begin
        r_s2_ray <= r_s1_ray;
        for (int i = 0; i < 3; i++) begin
            r_s2_dd[i] <= 64'($signed(r_s1_ray.d[i])) * 64'($signed(r_s1_ray.d[i]));
            r_s2_od[i] <= 65'(r_s1_oc[i]) * 65'($signed(r_s1_ray.d[i]));
            r_s2_oo[i] <= 66'(r_s1_oc[i]) * 66'(r_s1_oc[i]);
        end
    end

    // a, half_b and c
    always_ff @(posedge i_clk) begin
        r_s3_ray <= r_s2_ray;
        r_s3_a   <= A_W'(r_s2_dd[0]) + A_W'(r_s2_dd[1]) + A_W'(r_s2_dd[2]);
        r_s3_hb  <= 66'(r_s2_od[0]) + 66'(r_s2_od[1]) + 66'(r_s2_od[2]);
        r_s3_c   <= 67'(r_s2_oo[0]) + 67'(r_s2_oo[1]) + 67'(r_s2_oo[2])
                  - $signed({5'b0, i_cfg.rsq});
    end

    // magnitudes for the wide products
    always_comb begin
        n_hb_abs = r_s3_hb[65] ? 66'(-r_s3_hb) : r_s3_hb;
        n_c_abs  = r_s3_c[66]  ? 67'(-r_s3_c)  : r_s3_c;
    end

    always_ff @(posedge i_clk) begin
        r_s4_ray   <= r_s3_ray;
        r_s4_a     <= r_s3_a;
        r_s4_hb    <= r_s3_hb;
        r_s4_hbm   <= n_hb_abs[64:0];
        r_s4_cm    <= n_c_abs[65:0];
        r_s4_cneg  <= r_s3_c[66];
        r_s4_azero <= (r_s3_a == '0);
    end

    // 33 x 33 partial products of half_b^2 and a*|c|
    always_ff @(posedge i_clk) begin
        r_s5_ray   <= r_s4_ray;
        r_s5_a     <= r_s4_a;
        r_s5_hb    <= r_s4_hb;
        r_s5_cneg  <= r_s4_cneg;
        r_s5_azero <= r_s4_azero;
        r_s5_hh    <= 66'({1'b0, r_s4_hbm[64:33]}) * 66'({1'b0, r_s4_hbm[64:33]});
        r_s5_hl    <= 66'({1'b0, r_s4_hbm[64:33]}) * 66'(r_s4_hbm[32:0]);
        r_s5_ll    <= 66'(r_s4_hbm[32:0]) * 66'(r_s4_hbm[32:0]);
        r_s5_p11   <= 66'({2'b0, r_s4_a[63:33]}) * 66'(r_s4_cm[65:33]);
        r_s5_p10   <= 66'({2'b0, r_s4_a[63:33]}) * 66'(r_s4_cm[32:0]);
        r_s5_p01   <= 66'(r_s4_a[32:0]) * 66'(r_s4_cm[65:33]);
        r_s5_p00   <= 66'(r_s4_a[32:0]) * 66'(r_s4_cm[32:0]);
    end

    // combine partial products
    always_ff @(posedge i_clk) begin
        r_s6_ray   <= r_s5_ray;
        r_s6_a     <= r_s5_a;
        r_s6_hb    <= r_s5_hb;
        r_s6_cneg  <= r_s5_cneg;
        r_s6_azero <= r_s5_azero;
        r_s6_hb2   <= (132'(r_s5_hh) << 66) + (132'(r_s5_hl) << 34) + 132'(r_s5_ll);
        r_s6_ac    <= (132'(r_s5_p11) << 66)
                    + ((132'(r_s5_p10) + 132'(r_s5_p01)) << 33) + 132'(r_s5_p00);
    end

    // discriminant, miss on negative or zero-length direction
    always_comb begin
        if (r_s6_cneg)
            n_disc = $signed({1'b0, r_s6_hb2}) + $signed({1'b0, r_s6_ac});
        else
            n_disc = $signed({1'b0, r_s6_hb2}) - $signed({1'b0, r_s6_ac});
    end

    always_ff @(posedge i_clk) begin
        r_s7_ray  <= r_s6_ray;
        r_s7_a    <= r_s6_a;
        r_s7_hb   <= r_s6_hb;
        r_s7_miss <= r_s6_azero | n_disc[132];
        r_s7_disc <= n_disc[DISC_W-1:0];
    end

    // ------------------------------------------------------------------
    // integer square root, one root bit per stage
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < SQ_N; k++) begin : l_sq
            logic [REM_W-1:0]  v_rem;
            logic [REM_W-1:0]  v_cur;
            logic [REM_W-1:0]  v_trial;
            logic [SQ_N-1:0]   v_root;
            logic [DISC_W-1:0] v_rad;
            if (k == 0) begin
                v_rem        = '0;
                v_root       = '0;
                v_rad        = r_s7_disc;
                n_sq_vld[k]  = r_s7_vld;
                n_sq_miss[k] = r_s7_miss;
                n_sq_hb[k]   = r_s7_hb;
                n_sq_a[k]    = r_s7_a;
                n_sq_ray[k]  = r_s7_ray;
            end else begin
                v_rem        = r_sq_rem[k-1];
                v_root       = r_sq_root[k-1];
                v_rad        = r_sq_rad[k-1];
                n_sq_vld[k]  = r_sq_vld[k-1];
                n_sq_miss[k] = r_sq_miss[k-1];
                n_sq_hb[k]   = r_sq_hb[k-1];
                n_sq_a[k]    = r_sq_a[k-1];
                n_sq_ray[k]  = r_sq_ray[k-1];
            end
            v_cur   = {v_rem[REM_W-3:0], v_rad[DISC_W-1 -: 2]};
            v_trial = {v_root, 2'b01};
            if (v_cur >= v_trial) begin
                n_sq_rem[k]  = v_cur - v_trial;
                n_sq_root[k] = {v_root[SQ_N-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = v_cur;
                n_sq_root[k] = {v_root[SQ_N-2:0], 1'b0};
            end
            n_sq_rad[k] = {v_rad[DISC_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_miss <= n_sq_miss;
        r_sq_rem  <= n_sq_rem;
        r_sq_root <= n_sq_root;
        r_sq_rad  <= n_sq_rad;
        r_sq_hb   <= n_sq_hb;
        r_sq_a    <= n_sq_a;
        r_sq_ray  <= n_sq_ray;
    end

    // ------------------------------------------------------------------
    // root numerators: nearer -hb - s, farther -hb + s
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s8_ray    <= r_sq_ray[SQ_N-1];
        r_s8_a      <= r_sq_a[SQ_N-1];
        r_s8_miss   <= r_sq_miss[SQ_N-1];
        r_s8_num[0] <= -68'(r_sq_hb[SQ_N-1]) - 68'($signed({1'b0, r_sq_root[SQ_N-1]}));
        r_s8_num[1] <= -68'(r_sq_hb[SQ_N-1]) + 68'($signed({1'b0, r_sq_root[SQ_N-1]}));
    end

    always_comb begin
        for (int j = 0; j < 2; j++)
            n_num_abs[j] = r_s8_num[j][67] ? 68'(-r_s8_num[j]) : r_s8_num[j];
    end

    always_ff @(posedge i_clk) begin
        r_s9_ray  <= r_s8_ray;
        r_s9_a    <= r_s8_a;
        r_s9_miss <= r_s8_miss;
        for (int j = 0; j < 2; j++) begin
            r_s9_neg[j] <= r_s8_num[j][67];
            r_s9_mag[j] <= n_num_abs[j][66:0];
        end
    end

    // ------------------------------------------------------------------
    // root dividers, one quotient bit per stage, two lanes
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin : l_dv
            logic [A_W-1:0]   v_rem [2];
            logic [NUM_W-1:0] v_wrd [2];
            logic [A_W-1:0]   v_a;
            logic [A_W:0]     v_cur;
            if (k == 0) begin
                for (int j = 0; j < 2; j++) begin
                    v_rem[j] = '0;
                    v_wrd[j] = {r_s9_mag[j], {FRAC_BITS{1'b0}}};
                end
                v_a          = r_s9_a;
                n_dv_vld[k]  = r_s9_vld;
                n_dv_miss[k] = r_s9_miss;
                n_dv_neg[k]  = r_s9_neg;
                n_dv_ray[k]  = r_s9_ray;
            end else begin
                for (int j = 0; j < 2; j++) begin
                    v_rem[j] = r_dv_rem[k-1][j];
                    v_wrd[j] = r_dv_wrd[k-1][j];
                end
                v_a          = r_dv_a[k-1];
                n_dv_vld[k]  = r_dv_vld[k-1];
                n_dv_miss[k] = r_dv_miss[k-1];
                n_dv_neg[k]  = r_dv_neg[k-1];
                n_dv_ray[k]  = r_dv_ray[k-1];
            end
            n_dv_a[k] = v_a;
            for (int j = 0; j < 2; j++) begin
                v_cur = {v_rem[j], v_wrd[j][NUM_W-1]};
                if (v_cur >= {1'b0, v_a}) begin
                    n_dv_rem[k][j] = A_W'(v_cur - {1'b0, v_a});
                    n_dv_wrd[k][j] = {v_wrd[j][NUM_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[k][j] = v_cur[A_W-1:0];
                    n_dv_wrd[k][j] = {v_wrd[j][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_miss <= n_dv_miss;
        r_dv_neg  <= n_dv_neg;
        r_dv_rem  <= n_dv_rem;
        r_dv_wrd  <= n_dv_wrd;
        r_dv_a    <= n_dv_a;
        r_dv_ray  <= n_dv_ray;
    end

    // apply numerator sign
    always_ff @(posedge i_clk) begin
        r_s10_ray  <= r_dv_ray[NUM_W-1];
        r_s10_miss <= r_dv_miss[NUM_W-1];
        for (int j = 0; j < 2; j++) begin
            if (r_dv_neg[NUM_W-1][j])
                r_s10_t[j] <= -$signed({1'b0, r_dv_wrd[NUM_W-1][j]});
            else
                r_s10_t[j] <= $signed({1'b0, r_dv_wrd[NUM_W-1][j]});
        end
    end

    // ------------------------------------------------------------------
    // interval test, nearer root first
    // ------------------------------------------------------------------
    always_comb begin
        n_tmin = QT_W'($signed(r_s10_ray.tmin));
        n_tmax = QT_W'($signed(r_s10_ray.tmax));
        for (int j = 0; j < 2; j++)
            n_ok[j] = !(r_s10_t[j] < n_tmin) && !(n_tmax < r_s10_t[j]);
    end

    always_ff @(posedge i_clk) begin
        r_s11_ray <= r_s10_ray;
        r_s11_hit <= !r_s10_miss && (n_ok[0] || n_ok[1]);
        r_s11_t   <= n_ok[0] ? r_s10_t[0][31:0] : r_s10_t[1][31:0];
    end

    // ------------------------------------------------------------------
    // hit point
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s12_hit <= r_s11_hit;
        r_s12_t   <= r_s11_t;
        r_s12_o   <= r_s11_ray.o;
        for (int i = 0; i < 3; i++)
            r_s12_prod[i] <= 64'($signed(r_s11_t)) * 64'($signed(r_s11_ray.d[i]));
    end

    // floor shift, add origin, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sh[i]  = r_s12_prod[i] >>> FRAC_BITS;
            n_sum[i] = 65'($signed(r_s12_o[i])) + 65'(n_sh[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s13_hit <= r_s12_hit;
        r_s13_t   <= r_s12_t;
        for (int i = 0; i < 3; i++) begin
            if ((&n_sum[i][64:31]) || !(|n_sum[i][64:31]))
                r_s13_p[i] <= n_sum[i][31:0];
            else
                r_s13_p[i] <= n_sum[i][64] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
    end

    // ------------------------------------------------------------------
    // normal numerator
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_s14_hit <= r_s13_hit;
        r_s14_t   <= r_s13_t;
        r_s14_p   <= r_s13_p;
        for (int i = 0; i < 3; i++)
            r_s14_diff[i] <= 33'($signed(r_s13_p[i])) - 33'($signed(i_cfg.c[i]));
    end

    always_comb begin
        for (int i = 0; i < 3; i++)
            n_dabs[i] = r_s14_diff[i][32] ? 33'(-r_s14_diff[i]) : r_s14_diff[i];
    end

    always_ff @(posedge i_clk) begin
        r_s15_hit <= r_s14_hit;
        r_s15_t   <= r_s14_t;
        r_s15_p   <= r_s14_p;
        for (int i = 0; i < 3; i++) begin
            r_s15_neg[i] <= r_s14_diff[i][32];
            r_s15_mag[i] <= n_dabs[i];
        end
    end

    // ------------------------------------------------------------------
    // normal dividers by radius, three lanes
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < ND_W; k++) begin : l_nd
            logic [RAD_W-1:0] v_rem [3];
            logic [ND_W-1:0]  v_wrd [3];
            logic [RAD_W:0]   v_cur;
            if (k == 0) begin
                for (int i = 0; i < 3; i++) begin
                    v_rem[i] = '0;
                    v_wrd[i] = {r_s15_mag[i], {FRAC_BITS{1'b0}}};
                end
                n_nd_vld[k] = r_s15_vld;
                n_nd_hit[k] = r_s15_hit;
                n_nd_t[k]   = r_s15_t;
                n_nd_p[k]   = r_s15_p;
                n_nd_neg[k] = r_s15_neg;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    v_rem[i] = r_nd_rem[k-1][i];
                    v_wrd[i] = r_nd_wrd[k-1][i];
                end
                n_nd_vld[k] = r_nd_vld[k-1];
                n_nd_hit[k] = r_nd_hit[k-1];
                n_nd_t[k]   = r_nd_t[k-1];
                n_nd_p[k]   = r_nd_p[k-1];
                n_nd_neg[k] = r_nd_neg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                v_cur = {v_rem[i], v_wrd[i][ND_W-1]};
                if (v_cur >= {1'b0, i_cfg.radius}) begin
                    n_nd_rem[k][i] = RAD_W'(v_cur - {1'b0, i_cfg.radius});
                    n_nd_wrd[k][i] = {v_wrd[i][ND_W-2:0], 1'b1};
                end else begin
                    n_nd_rem[k][i] = v_cur[RAD_W-1:0];
                    n_nd_wrd[k][i] = {v_wrd[i][ND_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nd_hit <= n_nd_hit;
        r_nd_t   <= n_nd_t;
        r_nd_p   <= n_nd_p;
        r_nd_neg <= n_nd_neg;
        r_nd_rem <= n_nd_rem;
        r_nd_wrd <= n_nd_wrd;
    end

    // apply sign of the offset
    always_ff @(posedge i_clk) begin
        r_s16_hit <= r_nd_hit[ND_W-1];
        r_s16_t   <= r_nd_t[ND_W-1];
        r_s16_p   <= r_nd_p[ND_W-1];
        for (int i = 0; i < 3; i++) begin
            if (r_nd_neg[ND_W-1][i])
                r_s16_n[i] <= -$signed({1'b0, r_nd_wrd[ND_W-1][i]});
            else
                r_s16_n[i] <= $signed({1'b0, r_nd_wrd[ND_W-1][i]});
        end
    end

    // ------------------------------------------------------------------
    // result register: saturate normal, zero it for a zero radius, clear everything on a miss
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_s16_hit) begin
            r_s17_res.hit      <= 1'b1;
            r_s17_res.t        <= r_s16_t;
            r_s17_res.p        <= r_s16_p;
            r_s17_res.material <= i_cfg.material;
            for (int i = 0; i < 3; i++) begin
                if (i_cfg.radius == '0)
                    r_s17_res.n[i] <= '0;
                else if ((&r_s16_n[i][ND_W:31]) || !(|r_s16_n[i][ND_W:31]))
                    r_s17_res.n[i] <= r_s16_n[i][31:0];
                else
                    r_s17_res.n[i] <= r_s16_n[i][ND_W] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
        end else begin
            r_s17_res <= '0;
        end
    end

    assign o_vld = r_s17_vld;
    assign o_res = r_s17_res;

endmodule

// ----- src/ray_sphere_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against one sphere, half-b quadratic form, Q-format fixed point.
//
//   channel   signals                        transfer
//   -------   ----------------------------   ---------------------------------
//   ray in    start, busy, i_origin_*, ...   rising edge with start & !busy
//   result    o_done, o_hit, o_hit_t, ...    rising edge ending the o_done cycle
//   config    psel, penable, pwrite, paddr   rising edge of access phase write
//
// One ray per cycle; busy is always low. The pipeline holds the 66-stage square root
// and the two dividers of 67 + FRAC_BITS and 33 + FRAC_BITS stages.
// Reset clears all valid bits and returns the registers to their defaults.
// The pipeline advances every cycle; results go out on o_done and are not held.
// ----------------------------------------------------------------------------
module ray_sphere_intersect #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // ray channel
    input  logic                       start,
    output logic                       busy,
    input  logic [31:0]                i_origin_x,
    input  logic [31:0]                i_origin_y,
    input  logic [31:0]                i_origin_z,
    input  logic [31:0]                i_dir_x,
    input  logic [31:0]                i_dir_y,
    input  logic [31:0]                i_dir_z,
    input  logic [31:0]                i_t_min,
    input  logic [31:0]                i_t_max,
    // result channel
    output logic                       o_done,
    output logic                       o_hit,
    output logic [31:0]                o_hit_t,
    output logic [31:0]                o_point_x,
    output logic [31:0]                o_point_y,
    output logic [31:0]                o_point_z,
    output logic [31:0]                o_normal_x,
    output logic [31:0]                o_normal_y,
    output logic [31:0]                o_normal_z,
    output logic [15:0]                o_hit_material,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rsi_pkg::CFG_AW-1:0] paddr,
    input  logic [rsi_pkg::CFG_DW-1:0] pwdata,
    output logic [rsi_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import rsi_pkg::*;

    t_cfg     r_cfg;
    t_ray     n_ray;
    t_hit     n_res;
    t_reg_idx n_idx;
    logic     n_wr;
    logic     n_vld;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_idx  = t_reg_idx'(paddr[5:3]);
    assign n_wr   = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c        <= '0;
            r_cfg.radius   <= 31'd65536;
            r_cfg.rsq      <= 62'h1_0000_0000;
            r_cfg.material <= '0;
        end else if (n_wr) begin
            case (n_idx)
                REG_CENTER_X:  r_cfg.c[0]     <= pwdata[31:0];
                REG_CENTER_Y:  r_cfg.c[1]     <= pwdata[31:0];
                REG_CENTER_Z:  r_cfg.c[2]     <= pwdata[31:0];
                REG_RADIUS:    r_cfg.radius   <= pwdata[30:0];
                REG_RADIUS_SQ: r_cfg.rsq      <= pwdata[61:0];
                REG_MATERIAL:  r_cfg.material <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (n_idx)
            REG_CENTER_X:  prdata = CFG_DW'(r_cfg.c[0]);
            REG_CENTER_Y:  prdata = CFG_DW'(r_cfg.c[1]);
            REG_CENTER_Z:  prdata = CFG_DW'(r_cfg.c[2]);
            REG_RADIUS:    prdata = CFG_DW'(r_cfg.radius);
            REG_RADIUS_SQ: prdata = CFG_DW'(r_cfg.rsq);
            REG_MATERIAL:  prdata = CFG_DW'(r_cfg.material);
            default:       prdata = '0;
        endcase
    end

    // gather the ray
    always_comb begin
        n_ray.o    = {i_origin_z, i_origin_y, i_origin_x};
        n_ray.d    = {i_dir_z, i_dir_y, i_dir_x};
        n_ray.tmin = i_t_min;
        n_ray.tmax = i_t_max;
    end

    rsi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_ray   (n_ray),
        .i_cfg   (r_cfg),
        .o_vld   (n_vld),
        .o_res   (n_res)
    );

    // spread the result over its ports
    assign o_done         = n_vld;
    assign o_hit          = n_res.hit;
    assign o_hit_t        = n_res.t;
    assign o_point_x      = n_res.p[0];
    assign o_point_y      = n_res.p[1];
    assign o_point_z      = n_res.p[2];
    assign o_normal_x     = n_res.n[0];
    assign o_normal_y     = n_res.n[1];
    assign o_normal_z     = n_res.n[2];
    assign o_hit_material = n_res.material;

endmodule
